// ===== design/chunk_directory_record_parser_macros.svh =====
// Assertion macros shared by the checker of the chunk directory record parser.
// No dependencies; included by the files that hold assertions.
`ifndef CHUNK_DIRECTORY_RECORD_PARSER_MACROS_SVH
`define CHUNK_DIRECTORY_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define CDRP_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while rst_n is low.
`define CDRP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== design/cdrp_pkg.sv =====
// Package of the chunk directory record parser: limits, codes, item types.
// No dependencies; used by every module of the block except cdrp_ram.
package cdrp_pkg;

    localparam int CHUNK_LIMIT  = 50;
    localparam int BYTE_LIMIT   = 2097152;
    localparam int STORE_DEPTH  = CHUNK_LIMIT - 1;
    localparam int COUNT_BYTES  = 4;
    localparam int POS_W        = $clog2(BYTE_LIMIT);
    localparam int RUN_W        = POS_W + 1;
    localparam int LEN_W        = POS_W;
    localparam int CIDX_W       = 6;
    localparam int SLOT_W       = $clog2(STORE_DEPTH + 2);
    localparam int ENTRY_W      = 32 + CIDX_W + LEN_W;

    localparam logic [1:0] ROLE_COUNT   = 2'd0;
    localparam logic [1:0] ROLE_DIR     = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;
    localparam logic [1:0] ROLE_IGNORED = 2'd3;

    localparam logic [2:0] VERD_BUSY     = 3'd0;
    localparam logic [2:0] VERD_ACCEPT   = 3'd1;
    localparam logic [2:0] VERD_LENGTH   = 3'd2;
    localparam logic [2:0] VERD_COUNT    = 3'd3;
    localparam logic [2:0] VERD_DIRCUT   = 3'd4;
    localparam logic [2:0] VERD_TOTAL    = 3'd5;
    localparam logic [2:0] VERD_PAYCUT   = 3'd6;
    localparam logic [2:0] VERD_TRAILING = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_record;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        role;
        logic [7:0]        payload_byte;
        logic [CIDX_W-1:0] chunk_index;
        logic [31:0]       chunk_ident;
        logic              chunk_final_byte;
        logic [2:0]        verdict;
    } t_out_item;

    typedef struct packed {
        logic [31:0]       ident;
        logic [CIDX_W-1:0] index;
        logic [LEN_W-1:0]  length;
    } t_entry;

endpackage

// ===== design/cdrp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/cdrp_front.sv =====
// Front of the parser: takes one byte a cycle while i_acc is high, tracks the record, fills the
// chunk store and forms the result of each byte. Depends on cdrp_pkg, cdrp_ram.
module cdrp_front import cdrp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_acc,
    input  t_in_item  i_in,
    output t_out_item o_res
);
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [31:0]       r_word, n_word;
    logic [CIDX_W-1:0] r_ctot, n_ctot;
    logic [RUN_W-1:0]  r_run, n_run;
    logic [SLOT_W-1:0] r_rtot, n_rtot;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [LEN_W-1:0]  r_left, n_left;
    logic [31:0]       r_pend, n_pend;
    logic [2:0]        r_err, n_err;
    logic [31:0]       r_cur_id, n_cur_id;
    logic [CIDX_W-1:0] r_cur_idx, n_cur_idx;
    logic              r_byp_v;
    t_entry            r_byp_d;

    logic              we;
    t_entry            wentry;
    logic [SLOT_W-1:0] raddr;
    logic [SLOT_W-1:0] eff_cur;
    logic [ENTRY_W-1:0] rdata;
    t_entry            nxt;
    t_out_item         res;

    logic [POS_W-1:0]  dir_end, rel;
    logic [31:0]       count, sum;
    logic [30:0]       len;
    logic [2:0]        err;
    logic              last, do_rearm;

    assign nxt = r_byp_v ? r_byp_d : t_entry'(rdata);
    assign last = i_in.end_of_record;

    always_comb begin
        n_pos = r_pos; n_word = r_word; n_ctot = r_ctot; n_run = r_run;
        n_rtot = r_rtot; n_cur = r_cur; n_left = r_left; n_pend = r_pend;
        n_err = r_err; n_cur_id = r_cur_id; n_cur_idx = r_cur_idx;
        res = '0;
        we = 1'b0;
        wentry = '0;
        err = VERD_BUSY;
        do_rearm = 1'b0;
        count = '0;
        sum = '0;
        len = '0;
        dir_end = POS_W'(COUNT_BYTES) + POS_W'({r_ctot, 3'b000});
        rel = r_pos - POS_W'(COUNT_BYTES);
        if (r_err != VERD_BUSY) begin
            res.role = ROLE_IGNORED;
            res.verdict = r_err;
            do_rearm = last;
        end else begin
            if (r_pos < POS_W'(COUNT_BYTES)) begin
                res.role = ROLE_COUNT;
                n_word = r_word | (32'(i_in.data_byte) << {r_pos[1:0], 3'b000});
                if (r_pos == POS_W'(3)) begin
                    count = n_word;
                    n_word = '0;
                    if (count >= 32'(CHUNK_LIMIT)) begin
                        err = VERD_COUNT;
                    end else begin
                        n_ctot = count[CIDX_W-1:0];
                        n_run = RUN_W'(COUNT_BYTES) + RUN_W'({count[CIDX_W-1:0], 3'b000});
                    end
                end
                if (last && err == VERD_BUSY) begin
                    if (r_pos < POS_W'(3)) err = VERD_LENGTH;
                    else if (n_ctot == '0) res.verdict = VERD_ACCEPT;
                    else err = VERD_DIRCUT;
                end
            end else if (r_pos < dir_end) begin
                res.role = ROLE_DIR;
                n_word = r_word | (32'(i_in.data_byte) << {rel[1:0], 3'b000});
                if (rel[2:0] == 3'd3) begin
                    n_pend = n_word;
                    n_word = '0;
                end else if (rel[2:0] == 3'd7) begin
                    len = n_word[30:0];
                    n_word = '0;
                    sum = 32'(r_run) + 32'(len);
                    n_run = sum[RUN_W-1:0];
                    if (sum >= 32'(BYTE_LIMIT)) begin
                        err = VERD_TOTAL;
                    end else if (!n_word[31] && !r_word[31] && len != '0
                                 && r_rtot < SLOT_W'(STORE_DEPTH)) begin
                        // Nothing to do here; the store write is formed below.
                    end
                end
                // The deferred flag is bit 31 of the completed size word.
                if (rel[2:0] == 3'd7 && err == VERD_BUSY && !(r_word[31] ||
                    i_in.data_byte[7]) && len != '0 && r_rtot < SLOT_W'(STORE_DEPTH)) begin
                    we = 1'b1;
                    wentry.ident = r_pend;
                    wentry.index = rel[CIDX_W+2:3];
                    wentry.length = len[LEN_W-1:0];
                    n_rtot = r_rtot + 1'b1;
                    if (r_rtot == '0) begin
                        n_cur_id = r_pend;
                        n_cur_idx = rel[CIDX_W+2:3];
                        n_left = len[LEN_W-1:0];
                    end
                end
                if (last && err == VERD_BUSY) begin
                    if (r_pos == dir_end - 1'b1) begin
                        if (n_rtot != '0) err = VERD_PAYCUT;
                        else res.verdict = VERD_ACCEPT;
                    end else begin
                        err = VERD_DIRCUT;
                    end
                end
            end else if (r_cur < r_rtot && r_cur < SLOT_W'(STORE_DEPTH)) begin
                res.role = ROLE_PAYLOAD;
                res.payload_byte = i_in.data_byte;
                res.chunk_index = r_cur_idx;
                res.chunk_ident = r_cur_id;
                if (r_left <= LEN_W'(1)) begin
                    res.chunk_final_byte = 1'b1;
                    n_cur = r_cur + 1'b1;
                    n_left = (n_cur < SLOT_W'(STORE_DEPTH)) ? nxt.length : '0;
                    n_cur_id = nxt.ident;
                    n_cur_idx = nxt.index;
                end else begin
                    n_left = r_left - 1'b1;
                end
                if (last) begin
                    if (n_cur >= r_rtot) res.verdict = VERD_ACCEPT;
                    else err = VERD_PAYCUT;
                end
            end else begin
                res.role = ROLE_IGNORED;
                err = VERD_TRAILING;
            end

            if (err == VERD_BUSY && res.verdict != VERD_ACCEPT
                && r_pos == POS_W'(BYTE_LIMIT - 1)) begin
                err = VERD_LENGTH;
            end

            n_pos = r_pos + 1'b1;
            if (err != VERD_BUSY) begin
                res.verdict = err;
                if (last) do_rearm = 1'b1;
                else n_err = err;
            end else if (last) begin
                do_rearm = 1'b1;
            end
        end
        if (do_rearm) begin
            n_pos = '0; n_word = '0; n_ctot = '0; n_run = '0; n_rtot = '0;
            n_cur = '0; n_left = '0; n_pend = '0; n_err = VERD_BUSY;
        end
    end

    // The store is read one slot ahead of the current chunk, so the next
    // chunk's entry is ready the cycle the current one ends.
    always_comb begin
        eff_cur = i_acc ? n_cur : r_cur;
        raddr = eff_cur + 1'b1;
        if (raddr >= SLOT_W'(STORE_DEPTH)) raddr = '0;
    end

    cdrp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STORE_DEPTH),
        .AW   (SLOT_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we && i_acc),
        .i_waddr(r_rtot),
        .i_wdata(ENTRY_W'(wentry)),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0; r_word <= '0; r_ctot <= '0; r_run <= '0; r_rtot <= '0;
            r_cur <= '0; r_left <= '0; r_pend <= '0; r_err <= VERD_BUSY;
            r_byp_v <= 1'b0;
        end else begin
            r_byp_v <= we && i_acc && (r_rtot == raddr);
            if (i_acc) begin
                r_pos <= n_pos; r_word <= n_word; r_ctot <= n_ctot; r_run <= n_run;
                r_rtot <= n_rtot; r_cur <= n_cur; r_left <= n_left; r_pend <= n_pend;
                r_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_d <= wentry;
        if (i_acc) begin
            r_cur_id <= n_cur_id;
            r_cur_idx <= n_cur_idx;
        end
    end

    assign o_res = res;
endmodule

// ===== design/cdrp_queue.sv =====
// Back of the parser: a two-entry result queue that drives the output channel.
// Depends on cdrp_pkg.
module cdrp_queue import cdrp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);
    t_out_item  r_slot [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop = o_valid && !i_stall;
    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
            r_wr <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_data;
    end
endmodule

// ===== design/chunk_directory_record_parser.sv =====
// Top level of the chunk directory record parser: front parser and result queue.
// Depends on cdrp_pkg, cdrp_front, cdrp_queue.
//
//   channel   direction   ports                     request
//   input     in          i_valid, o_stall, i_in    one record byte
//   output    out         o_valid, i_stall, o_out   one result per byte
//
// One byte is taken every cycle while o_stall is low; its result reaches the output through a queue register.
// The chunk store is read one slot ahead, so chunks of any length follow
// each other with no gap. Reset is synchronous and active low.
// Input stalls only while both queue entries hold untaken results.
module chunk_directory_record_parser import cdrp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_out
);
    logic      acc;
    logic      full;
    t_out_item res;

    assign o_stall = full;
    assign acc = i_valid && !full;

    cdrp_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_acc  (acc),
        .i_in   (i_in),
        .o_res  (res)
    );

    cdrp_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (acc),
        .i_data (res),
        .o_full (full),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_out)
    );
endmodule

// ===== design/cdrp_checker.sv =====
// Port-level checker of the chunk directory record parser, bound to the top.
// Depends on cdrp_pkg and chunk_directory_record_parser_macros.svh.
`include "chunk_directory_record_parser_macros.svh"
module cdrp_checker import cdrp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input t_in_item  i_in,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_out
);
    `CDRP_ASSERT_IMPL(a_nonpayload_clean, i_clk, i_rst_n, o_valid && o_out.role != ROLE_PAYLOAD, o_out.payload_byte == 8'd0 && o_out.chunk_final_byte == 1'b0 && o_out.chunk_index == '0)
    `CDRP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out))
    `CDRP_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_in))
    `CDRP_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid && !o_stall)
endmodule

bind chunk_directory_record_parser cdrp_checker u_checker (.*);
